[src/rrsg_pkg.sv]
// Package for the rounded-rectangle span generator: sizes, limits and the
// request record that travels from the front end through the queue to the back end.
// No dependencies.
package rrsg_pkg;

   localparam int MAX_RADIUS       = 32;
   localparam int MIN_ROUND_RADIUS = 3;
   localparam int SPAN_LIMIT       = 64;

   localparam int COORD_IN_W  = 10;
   localparam int SIZE_IN_W   = 9;
   localparam int RADIUS_W    = 6;
   localparam int CRD_W       = 12;
   localparam int COUNT_W     = $clog2(SPAN_LIMIT + 1);
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic signed [COORD_IN_W-1:0] x;
      logic signed [COORD_IN_W-1:0] y;
      logic [SIZE_IN_W-1:0]         w;
      logic [SIZE_IN_W-1:0]         h;
      logic [RADIUS_W-1:0]          r;
      logic                         square;
   } rrsg_item_type;

   // Push side and pop side of the request queue.
   typedef struct packed {
      logic          push;
      rrsg_item_type item;
   } rrsg_push_type;

   typedef struct packed {
      logic          nonempty;
      rrsg_item_type item;
   } rrsg_head_type;

endpackage

[src/rrsg_front.sv]
// Front end: accepts a request, saturates the radius and marks square-corner requests.
// Depends on rrsg_pkg.
module rrsg_front (
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [rrsg_pkg::COORD_IN_W-1:0] req_rect_x,
   input  logic signed [rrsg_pkg::COORD_IN_W-1:0] req_rect_y,
   input  logic [rrsg_pkg::SIZE_IN_W-1:0]         req_rect_w,
   input  logic [rrsg_pkg::SIZE_IN_W-1:0]         req_rect_h,
   input  logic [rrsg_pkg::RADIUS_W-1:0]          req_corner_radius,
   input  logic                                   queue_full,
   output rrsg_pkg::rrsg_push_type                push_out
);

   logic [rrsg_pkg::RADIUS_W-1:0] radius_sat;

   always_comb begin
      if (req_corner_radius > rrsg_pkg::RADIUS_W'(rrsg_pkg::MAX_RADIUS)) begin
         radius_sat = rrsg_pkg::RADIUS_W'(rrsg_pkg::MAX_RADIUS);
      end else begin
         radius_sat = req_corner_radius;
      end
   end

   assign req_stall            = queue_full;
   assign push_out.push        = req_valid && !queue_full;
   assign push_out.item.x      = req_rect_x;
   assign push_out.item.y      = req_rect_y;
   assign push_out.item.w      = req_rect_w;
   assign push_out.item.h      = req_rect_h;
   assign push_out.item.r      = radius_sat;
   assign push_out.item.square = radius_sat < rrsg_pkg::RADIUS_W'(rrsg_pkg::MIN_ROUND_RADIUS);

endmodule

[src/rrsg_queue.sv]
// Two-entry request queue between the front end and the span sequencer.
// Depends on rrsg_pkg.
module rrsg_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  rrsg_pkg::rrsg_push_type push_in,
   input  logic                    pop,
   output logic                    full,
   output rrsg_pkg::rrsg_head_type head_out
);

   localparam int PTR_W = $clog2(rrsg_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(rrsg_pkg::QUEUE_DEPTH + 1);

   rrsg_pkg::rrsg_item_type entry_ff [rrsg_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full              = count_ff == CNT_W'(rrsg_pkg::QUEUE_DEPTH);
   assign head_out.nonempty = count_ff != '0;
   assign head_out.item     = entry_ff[rd_ptr_ff];
   assign do_pop            = pop && head_out.nonempty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_in.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(rrsg_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(rrsg_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_in.push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_in.push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.push) begin
         entry_ff[wr_ptr_ff] <= push_in.item;
      end
   end

endmodule

[src/rrsg_back.sv]
// Back end: midpoint circle sequencer that emits the spans of one request
// into a registered result stage. Depends on rrsg_pkg.
module rrsg_back (
   input  logic                                     clock,
   input  logic                                     reset,
   input  rrsg_pkg::rrsg_head_type                  head_in,
   output logic                                     pop,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [rrsg_pkg::CRD_W-1:0]        rsp_span_x,
   output logic signed [rrsg_pkg::CRD_W-1:0]        rsp_span_y,
   output logic signed [rrsg_pkg::CRD_W-1:0]        rsp_span_w,
   output logic signed [rrsg_pkg::CRD_W-1:0]        rsp_span_h,
   output logic                                     rsp_last
);

   localparam int CW = rrsg_pkg::CRD_W;
   localparam int RW = rrsg_pkg::RADIUS_W;
   localparam int NW = rrsg_pkg::COUNT_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SQUARE = 3'd1;
   localparam logic [2:0] ST_STEP   = 3'd2;
   localparam logic [2:0] ST_TOP    = 3'd3;
   localparam logic [2:0] ST_BOT    = 3'd4;
   localparam logic [2:0] ST_UPPER  = 3'd5;
   localparam logic [2:0] ST_LOWER  = 3'd6;
   localparam logic [2:0] ST_CENTER = 3'd7;

   logic [2:0] state_ff, state_in;
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in, w_ff, w_in, h_ff, h_in;
   logic signed [CW-1:0] top_ff, top_in, bot_ff, bot_in;
   logic signed [CW-1:0] upper_ff, upper_in, lower_ff, lower_in;
   logic signed [CW-1:0] wadj_ff, wadj_in, err_ff, err_in;
   logic [RW-1:0] r_ff, r_in, px_ff, px_in, py_ff, py_in, prev_ff, prev_in;
   logic [NW-1:0] n_ff, n_in;

   logic valid_ff, valid_in;
   logic signed [CW-1:0] sx_ff, sx_in, sy_ff, sy_in, sw_ff, sw_in, sh_ff, sh_in;
   logic last_ff, last_in;

   logic out_free, emit;
   logic signed [CW-1:0] e_x, e_y, e_w, e_h;
   logic e_last;

   logic signed [CW-1:0] r12, px12, py12, prev12, pxn12, dlt12;
   logic signed [CW-1:0] hx12, hy12, hw12, hh12, hr12;
   logic [RW-1:0] px_next;

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      r12     = CW'(r_ff);
      px12    = CW'(px_ff);
      py12    = CW'(py_ff);
      prev12  = CW'(prev_ff);
      px_next = px_ff + 1'b1;
      pxn12   = CW'(px_next);
      dlt12   = px12 - prev12;
      hx12    = CW'(head_in.item.x);
      hy12    = CW'(head_in.item.y);
      hw12    = CW'(head_in.item.w);
      hh12    = CW'(head_in.item.h);
      hr12    = CW'(head_in.item.r);
   end

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      w_in     = w_ff;
      h_in     = h_ff;
      r_in     = r_ff;
      top_in   = top_ff;
      bot_in   = bot_ff;
      upper_in = upper_ff;
      lower_in = lower_ff;
      wadj_in  = wadj_ff;
      err_in   = err_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      prev_in  = prev_ff;
      n_in     = n_ff;
      pop      = 1'b0;
      emit     = 1'b0;
      e_x      = x_ff + r12 - px12;
      e_y      = top_ff;
      e_w      = (px12 <<< 1) + wadj_ff;
      e_h      = CW'(1);
      e_last   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (head_in.nonempty) begin
               pop      = 1'b1;
               x_in     = hx12;
               y_in     = hy12;
               w_in     = hw12;
               h_in     = hh12;
               r_in     = head_in.item.r;
               top_in   = hy12;
               bot_in   = hy12 + hh12;
               upper_in = hy12 + hr12;
               lower_in = hy12 + hh12 - hr12;
               wadj_in  = hw12 - (hr12 <<< 1);
               err_in   = CW'(1) - (hr12 <<< 1);
               px_in    = '0;
               py_in    = head_in.item.r + 1'b1;
               prev_in  = '0;
               n_in     = '0;
               state_in = head_in.item.square ? ST_SQUARE : ST_STEP;
            end
         end
         ST_SQUARE: begin
            e_x    = x_ff;
            e_y    = y_ff;
            e_w    = w_ff;
            e_h    = h_ff;
            e_last = 1'b1;
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_STEP: begin
            if (py_ff >= px_ff && n_ff <= NW'(rrsg_pkg::SPAN_LIMIT - 5)) begin
               px_in = px_next;
               if (err_ff[CW-1]) begin
                  err_in = err_ff + (pxn12 <<< 2) + CW'(6);
               end else begin
                  // A step that lowers y closes one row of each corner.
                  err_in   = err_ff + ((pxn12 - py12) <<< 2) + CW'(10);
                  py_in    = py_ff - 1'b1;
                  state_in = ST_TOP;
               end
            end else begin
               state_in = ST_CENTER;
            end
         end
         ST_TOP: begin
            if (out_free) begin
               emit     = 1'b1;
               top_in   = top_ff + CW'(1);
               state_in = ST_BOT;
            end
         end
         ST_BOT: begin
            e_y = bot_ff - CW'(1);
            if (out_free) begin
               emit     = 1'b1;
               bot_in   = bot_ff - CW'(1);
               state_in = ST_UPPER;
            end
         end
         ST_UPPER: begin
            e_x = x_ff + r12 - py12;
            e_y = upper_ff - dlt12;
            e_w = (py12 <<< 1) + wadj_ff;
            e_h = dlt12;
            if (out_free) begin
               emit     = 1'b1;
               upper_in = upper_ff - dlt12;
               state_in = ST_LOWER;
            end
         end
         ST_LOWER: begin
            e_x = x_ff + r12 - py12;
            e_y = lower_ff;
            e_w = (py12 <<< 1) + wadj_ff;
            e_h = dlt12;
            if (out_free) begin
               emit     = 1'b1;
               lower_in = lower_ff + dlt12;
               prev_in  = px_ff;
               n_in     = n_ff + NW'(4);
               state_in = ST_STEP;
            end
         end
         ST_CENTER: begin
            e_x    = x_ff;
            e_y    = y_ff + r12;
            e_w    = w_ff;
            e_h    = h_ff - (r12 <<< 1);
            e_last = 1'b1;
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      sw_in    = sw_ff;
      sh_in    = sh_ff;
      last_in  = last_ff;
      if (emit) begin
         valid_in = 1'b1;
         sx_in    = e_x;
         sy_in    = e_y;
         sw_in    = e_w;
         sh_in    = e_h;
         last_in  = e_last;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      w_ff     <= w_in;
      h_ff     <= h_in;
      r_ff     <= r_in;
      top_ff   <= top_in;
      bot_ff   <= bot_in;
      upper_ff <= upper_in;
      lower_ff <= lower_in;
      wadj_ff  <= wadj_in;
      err_ff   <= err_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      prev_ff  <= prev_in;
      n_ff     <= n_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      sw_ff    <= sw_in;
      sh_ff    <= sh_in;
      last_ff  <= last_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_span_x = sx_ff;
   assign rsp_span_y = sy_ff;
   assign rsp_span_w = sw_ff;
   assign rsp_span_h = sh_ff;
   assign rsp_last   = last_ff;

endmodule

[src/rounded_rect_span_generator_core.sv]
// Top level of the rounded-rectangle span generator: front end, request queue, back end.
// Depends on rrsg_pkg, rrsg_front, rrsg_queue and rrsg_back.
//
//   Channel   Ports             Moves
//   request   req_*   (in)      one rectangle with corner radius per transfer
//   response  rsp_*   (out)     one fill span per transfer, rsp_last on the final one
//
// A square-corner request passes through the idle and square states of the back end.
// A rounded one passes through the idle state, the step state for each midpoint circle step
// and one state per span; at radius 32 that is 24 steps and 45 spans, from the single circle sequencer.
// The two-entry queue accepts new requests while the back end works, until it is full.
// Reset clears the queue and the sequencer; a stalled response holds the sequencer.
module rounded_rect_span_generator_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [rrsg_pkg::COORD_IN_W-1:0] req_rect_x,
   input  logic signed [rrsg_pkg::COORD_IN_W-1:0] req_rect_y,
   input  logic [rrsg_pkg::SIZE_IN_W-1:0]         req_rect_w,
   input  logic [rrsg_pkg::SIZE_IN_W-1:0]         req_rect_h,
   input  logic [rrsg_pkg::RADIUS_W-1:0]          req_corner_radius,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [rrsg_pkg::CRD_W-1:0]      rsp_span_x,
   output logic signed [rrsg_pkg::CRD_W-1:0]      rsp_span_y,
   output logic signed [rrsg_pkg::CRD_W-1:0]      rsp_span_w,
   output logic signed [rrsg_pkg::CRD_W-1:0]      rsp_span_h,
   output logic                                   rsp_last
);

   rrsg_pkg::rrsg_push_type push;
   rrsg_pkg::rrsg_head_type head;
   logic                    queue_full;
   logic                    pop;

   rrsg_front u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rect_x        (req_rect_x),
      .req_rect_y        (req_rect_y),
      .req_rect_w        (req_rect_w),
      .req_rect_h        (req_rect_h),
      .req_corner_radius (req_corner_radius),
      .queue_full        (queue_full),
      .push_out          (push)
   );

   rrsg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_in  (push),
      .pop      (pop),
      .full     (queue_full),
      .head_out (head)
   );

   rrsg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_in    (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_span_x (rsp_span_x),
      .rsp_span_y (rsp_span_y),
      .rsp_span_w (rsp_span_w),
      .rsp_span_h (rsp_span_h),
      .rsp_last   (rsp_last)
   );

endmodule

[tb/rrsg_span_checker.sv]
// Checker for the rounded-rectangle span generator: watches both channels, predicts the
// fill spans of every accepted request and compares each response transfer in order.
// Depends on rrsg_pkg for field widths, the radius limits and the span limit.
module rrsg_span_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic signed [rrsg_pkg::COORD_IN_W-1:0] req_rect_x,
   input  logic signed [rrsg_pkg::COORD_IN_W-1:0] req_rect_y,
   input  logic [rrsg_pkg::SIZE_IN_W-1:0]         req_rect_w,
   input  logic [rrsg_pkg::SIZE_IN_W-1:0]         req_rect_h,
   input  logic [rrsg_pkg::RADIUS_W-1:0]          req_corner_radius,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic signed [rrsg_pkg::CRD_W-1:0]      rsp_span_x,
   input  logic signed [rrsg_pkg::CRD_W-1:0]      rsp_span_y,
   input  logic signed [rrsg_pkg::CRD_W-1:0]      rsp_span_w,
   input  logic signed [rrsg_pkg::CRD_W-1:0]      rsp_span_h,
   input  logic                                   rsp_last,
   output int                                     fail_count,
   output int                                     spans_pending
);

   typedef struct packed {
      logic signed [rrsg_pkg::CRD_W-1:0] x;
      logic signed [rrsg_pkg::CRD_W-1:0] y;
      logic signed [rrsg_pkg::CRD_W-1:0] w;
      logic signed [rrsg_pkg::CRD_W-1:0] h;
      logic                              last;
   } fill_span_type;

   fill_span_type expected_spans[$];

   initial begin
      fail_count    = 0;
      spans_pending = 0;
   end

   function automatic void add_span(input int sx, input int sy, input int sw, input int sh,
                                    input logic fin);
      fill_span_type s;
      s.x    = sx[rrsg_pkg::CRD_W-1:0];
      s.y    = sy[rrsg_pkg::CRD_W-1:0];
      s.w    = sw[rrsg_pkg::CRD_W-1:0];
      s.h    = sh[rrsg_pkg::CRD_W-1:0];
      s.last = fin;
      expected_spans.push_back(s);
   endfunction

   // Walks the midpoint circle of radius r+1 and queues the spans of one rectangle.
   function automatic void predict_spans(input int x, input int y, input int w, input int h,
                                         input int radius);
      int r, top, bot, upper, lower, prev, wadj, px, py, err, dlt, n;
      r = (radius > rrsg_pkg::MAX_RADIUS) ? rrsg_pkg::MAX_RADIUS : radius;
      if (r < rrsg_pkg::MIN_ROUND_RADIUS) begin
         add_span(x, y, w, h, 1'b1);
         return;
      end
      top   = y;
      bot   = y + h;
      upper = y + r;
      lower = y + h - r;
      prev  = 0;
      wadj  = w - 2 * r;
      px    = 0;
      py    = r + 1;
      err   = 3 - 2 * py;
      n     = 0;
      while (py >= px && n + 4 <= rrsg_pkg::SPAN_LIMIT - 1) begin
         px++;
         if (err < 0) begin
            err += 4 * px + 6;
         end else begin
            err += 4 * (px - py) + 10;
            py--;
            add_span(x + r - px, top, 2 * px + wadj, 1, 1'b0);
            top++;
            bot--;
            add_span(x + r - px, bot, 2 * px + wadj, 1, 1'b0);
            dlt = px - prev;
            upper -= dlt;
            add_span(x + r - py, upper, 2 * py + wadj, dlt, 1'b0);
            add_span(x + r - py, lower, 2 * py + wadj, dlt, 1'b0);
            lower += dlt;
            prev = px;
            n += 4;
         end
      end
      add_span(x, y + r, w, h - 2 * r, 1'b1);
   endfunction

   always @(posedge clock) begin
      fill_span_type want;
      if (!reset) begin
         // Responses are checked before the request of the same edge is predicted;
         // a request can never produce a span in the cycle it is accepted.
         if (rsp_valid && !rsp_stall) begin
            if (expected_spans.size() == 0) begin
               $error("unexpected span transfer: x %0d y %0d w %0d h %0d last %0b",
                      rsp_span_x, rsp_span_y, rsp_span_w, rsp_span_h, rsp_last);
               fail_count++;
            end else begin
               want = expected_spans.pop_front();
               if (rsp_span_x !== want.x) begin
                  $error("span_x: expected %0d, got %0d", want.x, rsp_span_x);
                  fail_count++;
               end
               if (rsp_span_y !== want.y) begin
                  $error("span_y: expected %0d, got %0d", want.y, rsp_span_y);
                  fail_count++;
               end
               if (rsp_span_w !== want.w) begin
                  $error("span_w: expected %0d, got %0d", want.w, rsp_span_w);
                  fail_count++;
               end
               if (rsp_span_h !== want.h) begin
                  $error("span_h: expected %0d, got %0d", want.h, rsp_span_h);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_last);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            predict_spans(req_rect_x, req_rect_y, req_rect_w, req_rect_h, req_corner_radius);
      end
      spans_pending <= expected_spans.size();
   end

endmodule

[tb/tb_rounded_rect_span_generator_core.sv]
// Testbench top for the rounded-rectangle span generator: drives directed and random
// rectangles with random idling on both channels and reports the checker's verdict.
// Depends on rrsg_pkg, rounded_rect_span_generator_core and rrsg_span_checker.
module tb_rounded_rect_span_generator_core;

   logic                                   clock;
   logic                                   reset;
   logic                                   req_valid;
   logic                                   req_stall;
   logic signed [rrsg_pkg::COORD_IN_W-1:0] req_rect_x;
   logic signed [rrsg_pkg::COORD_IN_W-1:0] req_rect_y;
   logic [rrsg_pkg::SIZE_IN_W-1:0]         req_rect_w;
   logic [rrsg_pkg::SIZE_IN_W-1:0]         req_rect_h;
   logic [rrsg_pkg::RADIUS_W-1:0]          req_corner_radius;
   logic                                   rsp_valid;
   logic                                   rsp_stall;
   logic signed [rrsg_pkg::CRD_W-1:0]      rsp_span_x;
   logic signed [rrsg_pkg::CRD_W-1:0]      rsp_span_y;
   logic signed [rrsg_pkg::CRD_W-1:0]      rsp_span_w;
   logic signed [rrsg_pkg::CRD_W-1:0]      rsp_span_h;
   logic                                   rsp_last;
   int                                     fail_count;
   int                                     spans_pending;
   bit                                     no_idling;

   rounded_rect_span_generator_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rect_x        (req_rect_x),
      .req_rect_y        (req_rect_y),
      .req_rect_w        (req_rect_w),
      .req_rect_h        (req_rect_h),
      .req_corner_radius (req_corner_radius),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_span_x        (rsp_span_x),
      .rsp_span_y        (rsp_span_y),
      .rsp_span_w        (rsp_span_w),
      .rsp_span_h        (rsp_span_h),
      .rsp_last          (rsp_last)
   );

   rrsg_span_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rect_x        (req_rect_x),
      .req_rect_y        (req_rect_y),
      .req_rect_w        (req_rect_w),
      .req_rect_h        (req_rect_h),
      .req_corner_radius (req_corner_radius),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_span_x        (rsp_span_x),
      .rsp_span_y        (rsp_span_y),
      .rsp_span_w        (rsp_span_w),
      .rsp_span_h        (rsp_span_h),
      .rsp_last          (rsp_last),
      .fail_count        (fail_count),
      .spans_pending     (spans_pending)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

   // The span receiver stalls in bursts until the final stretch of the run.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if (!no_idling && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Holds one rectangle on the request channel until its transfer.
   task automatic send_rect(input int x, input int y, input int w, input int h, input int r);
      if (!no_idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_rect_x        <= x[rrsg_pkg::COORD_IN_W-1:0];
      req_rect_y        <= y[rrsg_pkg::COORD_IN_W-1:0];
      req_rect_w        <= w[rrsg_pkg::SIZE_IN_W-1:0];
      req_rect_h        <= h[rrsg_pkg::SIZE_IN_W-1:0];
      req_corner_radius <= r[rrsg_pkg::RADIUS_W-1:0];
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (spans_pending != 0) @(posedge clock);
   endtask

   initial begin
      int r, w, h, pick;
      no_idling         = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_rect_x        = '0;
      req_rect_y        = '0;
      req_rect_w        = '0;
      req_rect_h        = '0;
      req_corner_radius = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Square corners, the smallest rounded radius, saturation, and corners too
      // large for the rectangle, which give nonpositive widths and heights.
      send_rect(0, 0, 10, 10, 0);
      send_rect(5, 5, 20, 20, 1);
      send_rect(-7, 3, 40, 30, 2);
      send_rect(0, 0, 40, 40, 3);
      send_rect(-512, -512, 511, 511, 32);
      send_rect(511, 511, 511, 511, 63);
      send_rect(100, -100, 100, 80, 33);
      send_rect(0, 0, 0, 0, 0);
      send_rect(0, 0, 0, 0, 10);
      send_rect(-512, 511, 5, 4, 20);
      send_rect(511, -512, 511, 0, 44);
      send_rect(0, 0, 1, 511, 4);
      send_rect(-1, -1, 64, 64, 31);
      send_rect(3, 3, 65, 65, 32);
      send_rect(-300, 200, 10, 300, 5);
      send_rect(-512, 511, 0, 511, 63);

      for (int i = 0; i < 300; i++) begin
         if (i == 150)
            wait_for_drain();
         if (i == 260)
            no_idling = 1'b1;
         pick = $urandom_range(0, 9);
         if (pick < 4)
            r = $urandom_range(0, 2);
         else if (pick < 8)
            r = $urandom_range(3, 20);
         else
            r = $urandom_range(21, 63);
         w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 511);
         h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 511);
         send_rect($urandom_range(0, 1023), $urandom_range(0, 1023), w, h, r);
      end

      wait_for_drain();
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

[sim.f]
src/rrsg_pkg.sv
src/rrsg_front.sv
src/rrsg_queue.sv
src/rrsg_back.sv
src/rounded_rect_span_generator_core.sv
tb/rrsg_span_checker.sv
tb/tb_rounded_rect_span_generator_core.sv
